// File: design/xmodem_checksum_receiver_top_defines.svh
// Assertion macros shared by the checker of the XMODEM checksum receiver.
// Depends on nothing; included by the checker file.
`ifndef XMODEM_CHECKSUM_RECEIVER_TOP_DEFINES_SVH
`define XMODEM_CHECKSUM_RECEIVER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define XCR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define XCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/xcr_pkg.sv
// Types and constants of the XMODEM checksum receiver.
// No dependencies; used by every RTL file of the block.
`default_nettype none

package xcr_pkg;

  localparam int MAX_RESULTS = 4;
  localparam int COUNT_W     = 3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_WAIT,
    PH_PACKET,
    PH_DONE
  } phase_t;

  localparam logic       CMD_START       = 1'b0;
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_CANCEL   = 2'd2;

  localparam logic [1:0] VERDICT_NONE    = 2'd0;
  localparam logic [1:0] VERDICT_COMMIT  = 2'd1;
  localparam logic [1:0] VERDICT_DISCARD = 2'd2;

  localparam logic [7:0] BYTE_SOH        = 8'd1;
  localparam logic [7:0] BYTE_EOT        = 8'd4;
  localparam logic [7:0] BYTE_ACK        = 8'd6;
  localparam logic [7:0] BYTE_NAK        = 8'd21;
  localparam logic [7:0] BYTE_CAN        = 8'd24;

  localparam logic [7:0] SLOT_LAST       = 8'd130;
  localparam logic [7:0] ALL_ONES        = 8'd255;
  localparam logic [7:0] RETRY_LIMIT_RST = 8'd10;

  typedef struct packed {
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [1:0] block_verdict;
    logic       finished;
    logic       success;
    logic       last_result;
  } result_t;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
    logic [1:0] byte_status;
  } item_t;

endpackage

`default_nettype wire

// File: design/xcr_core.sv
// Protocol engine: transfer state and the results of one item, in one pass.
// Depends on xcr_pkg.
`default_nettype none

module xcr_core (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cfg_wr_en,
  input  wire  [7:0]            cfg_wr_data,
  input  wire                   fire,
  input  xcr_pkg::item_t        item,
  output xcr_pkg::result_t [xcr_pkg::MAX_RESULTS-1:0] res,
  output logic [xcr_pkg::COUNT_W-1:0]                 res_count
);

  logic [7:0]      retry_limit;
  xcr_pkg::phase_t phase, phase_next;
  logic [7:0]      start_tries, start_tries_next;
  logic [7:0]      retry_count, retry_count_next;
  logic [7:0]      expected_block, expected_block_next;
  logic [7:0]      slot_index, slot_index_next;
  logic            any_bad_slot, any_bad_slot_next;
  logic [7:0]      got_block, got_block_next;
  logic [7:0]      got_complement, got_complement_next;
  logic [7:0]      running_sum, running_sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit    <= xcr_pkg::RETRY_LIMIT_RST;
      phase          <= xcr_pkg::PH_IDLE;
      start_tries    <= '0;
      retry_count    <= '0;
      expected_block <= 8'd1;
      slot_index     <= '0;
      any_bad_slot   <= 1'b0;
      got_block      <= '0;
      got_complement <= '0;
      running_sum    <= '0;
    end else begin
      if (cfg_wr_en) begin
        retry_limit <= cfg_wr_data;
      end
      if (fire) begin
        phase          <= phase_next;
        start_tries    <= start_tries_next;
        retry_count    <= retry_count_next;
        expected_block <= expected_block_next;
        slot_index     <= slot_index_next;
        any_bad_slot   <= any_bad_slot_next;
        got_block      <= got_block_next;
        got_complement <= got_complement_next;
        running_sum    <= running_sum_next;
      end
    end
  end

  always_comb begin
    logic       ok;
    logic [7:0] ch;
    logic [8:0] retry_inc;
    logic       over;
    logic       do_ctrl;
    logic       do_bump;
    logic       good;
    logic [xcr_pkg::COUNT_W-1:0] n;

    ok        = (item.byte_status == xcr_pkg::STATUS_OK);
    ch        = (item.byte_status >= xcr_pkg::STATUS_CANCEL) ? xcr_pkg::ALL_ONES : item.rx_byte;
    retry_inc = {1'b0, retry_count} + 9'd1;
    over      = (retry_inc > {1'b0, retry_limit});
    do_ctrl   = 1'b0;
    do_bump   = 1'b0;
    good      = 1'b0;
    n         = '0;
    res       = '0;

    phase_next          = phase;
    start_tries_next    = start_tries;
    retry_count_next    = retry_count;
    expected_block_next = expected_block;
    slot_index_next     = slot_index;
    any_bad_slot_next   = any_bad_slot;
    got_block_next      = got_block;
    got_complement_next = got_complement;
    running_sum_next    = running_sum;

    if (item.command == xcr_pkg::CMD_START) begin
      // restart: clear the transfer, discard an open packet
      start_tries_next      = 8'd1;
      retry_count_next      = '0;
      expected_block_next   = 8'd1;
      slot_index_next       = '0;
      any_bad_slot_next     = 1'b0;
      got_block_next        = '0;
      got_complement_next   = '0;
      running_sum_next      = '0;
      phase_next            = xcr_pkg::PH_START;
      res[0].reply_valid    = 1'b1;
      res[0].reply_byte     = xcr_pkg::BYTE_NAK;
      res[0].block_verdict  = (phase == xcr_pkg::PH_PACKET) ? xcr_pkg::VERDICT_DISCARD
                                                            : xcr_pkg::VERDICT_NONE;
      n = 3'd1;
    end else begin
      case (phase)
        xcr_pkg::PH_START: begin
          if (ok || ch != 8'd0) begin
            do_ctrl = 1'b1;
          end else if (start_tries < retry_limit) begin
            start_tries_next   = start_tries + 8'd1;
            res[0].reply_valid = 1'b1;
            res[0].reply_byte  = xcr_pkg::BYTE_NAK;
            n = 3'd1;
          end else begin
            do_ctrl = 1'b1;
          end
        end
        xcr_pkg::PH_WAIT: begin
          do_ctrl = 1'b1;
        end
        xcr_pkg::PH_PACKET: begin
          if (slot_index < xcr_pkg::SLOT_LAST) begin
            slot_index_next = slot_index + 8'd1;
            if (!ok) begin
              any_bad_slot_next = 1'b1;
            end else if (slot_index == 8'd0) begin
              got_block_next = ch;
            end else if (slot_index == 8'd1) begin
              got_complement_next = ch;
            end else begin
              running_sum_next     = running_sum + ch;
              res[0].payload_valid = 1'b1;
              res[0].payload_byte  = ch;
              n = 3'd1;
            end
          end else begin
            good = ok && !any_bad_slot && (got_block == expected_block) &&
                   ((xcr_pkg::ALL_ONES - got_complement) == got_block) &&
                   (ch == running_sum);
            slot_index_next    = '0;
            phase_next         = xcr_pkg::PH_WAIT;
            res[0].reply_valid = 1'b1;
            n = 3'd1;
            if (good) begin
              res[0].reply_byte    = xcr_pkg::BYTE_ACK;
              res[0].block_verdict = xcr_pkg::VERDICT_COMMIT;
              expected_block_next  = expected_block + 8'd1;
              retry_count_next     = '0;
            end else begin
              res[0].reply_byte    = xcr_pkg::BYTE_NAK;
              res[0].block_verdict = xcr_pkg::VERDICT_DISCARD;
              do_bump = 1'b1;
            end
          end
        end
        default: begin
          // idle or finished: ignore link events
        end
      endcase
    end

    if (do_ctrl) begin
      phase_next = xcr_pkg::PH_WAIT;
      if (ok && ch == xcr_pkg::BYTE_SOH) begin
        slot_index_next     = '0;
        any_bad_slot_next   = 1'b0;
        running_sum_next    = '0;
        got_block_next      = '0;
        got_complement_next = '0;
        phase_next          = xcr_pkg::PH_PACKET;
      end else if (ok && ch == xcr_pkg::BYTE_EOT) begin
        res[0].reply_valid = 1'b1;
        res[0].reply_byte  = xcr_pkg::BYTE_ACK;
        res[0].finished    = 1'b1;
        res[0].success     = 1'b1;
        phase_next         = xcr_pkg::PH_DONE;
        n = 3'd1;
      end else if (ok && ch == xcr_pkg::BYTE_CAN) begin
        retry_count_next = retry_limit;
      end else begin
        res[0].reply_valid = 1'b1;
        res[0].reply_byte  = xcr_pkg::BYTE_NAK;
        n = 3'd1;
        do_bump = 1'b1;
      end
    end

    if (do_bump) begin
      if (over) begin
        // out of retries: cancel three times and finish
        for (int i = 1; i < xcr_pkg::MAX_RESULTS; i++) begin
          res[i].reply_valid = 1'b1;
          res[i].reply_byte  = xcr_pkg::BYTE_CAN;
        end
        res[xcr_pkg::MAX_RESULTS-1].finished = 1'b1;
        phase_next = xcr_pkg::PH_DONE;
        n = 3'd4;
      end else begin
        retry_count_next = retry_inc[7:0];
      end
    end

    for (int i = 0; i < xcr_pkg::MAX_RESULTS; i++) begin
      res[i].last_result = (n != '0) && (i[xcr_pkg::COUNT_W-1:0] == n - 3'd1);
    end
    res_count = n;
  end

endmodule

`default_nettype wire

// File: design/xcr_burst.sv
// Result burst register: holds one item's results, presents one per cycle while ready.
// Depends on xcr_pkg.
`default_nettype none

module xcr_burst (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   load,
  input  wire  [xcr_pkg::COUNT_W-1:0]                 load_count,
  input  xcr_pkg::result_t [xcr_pkg::MAX_RESULTS-1:0] load_res,
  output logic                  can_load,
  output logic                  out_valid,
  input  wire                   out_ready,
  output xcr_pkg::result_t      out_res
);

  xcr_pkg::result_t [xcr_pkg::MAX_RESULTS-1:0] entries;
  logic [xcr_pkg::COUNT_W-1:0] count;
  logic pop;

  assign out_valid = (count != '0);
  assign out_res   = entries[0];
  assign pop       = out_valid && out_ready;
  // accept a new burst once the current one is gone or leaves this cycle
  assign can_load  = (count == '0) || (count == 3'd1 && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= load_count;
    end else if (pop) begin
      count <= count - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entries <= load_res;
    end else if (pop) begin
      for (int i = 0; i < xcr_pkg::MAX_RESULTS - 1; i++) begin
        entries[i] <= entries[i+1];
      end
    end
  end

endmodule

`default_nettype wire

// File: design/xmodem_checksum_receiver_top.sv
// Top level of the XMODEM checksum receiver: input register, engine, result burst.
// Depends on xcr_pkg, xcr_core and xcr_burst.
`default_nettype none

// XMODEM checksum receiver, link side. Each input item is either a start
// command (tuser = 0) or one link event (tuser = 1) carrying the received byte
// and its status. A start command sends NAK and resends NAK on timeouts until
// retry_limit NAKs have gone out; SOH opens a 131-slot packet whose 128 payload bytes are
// streamed out as they arrive, and the checksum slot brings a commit or
// discard verdict with ACK or NAK. EOT is ACKed and finishes with success;
// running out of retries sends CAN three times and finishes with failure.
// An item may cause zero to four result items; the last one carries tlast.
// Timing: an item is taken into the input register, evaluated by the
// combinational engine, and its results are loaded at once into the burst
// register, which presents one result per cycle while the output is ready.
// A new item can therefore be taken every cycle while the output side keeps
// up and each item causes at most one result; an item causing more results
// (four at most, for NAK plus three CANs) occupies the burst register, and the
// next item waits in the input register until the last of them is taken.
// retry_limit (reset 10) is written through cfg_wr_en / cfg_wr_data and must
// only change while no item is in flight.
module xmodem_checksum_receiver_top (
  input  wire         clk,
  input  wire         rst,
  // configuration: retry_limit
  input  wire         cfg_wr_en,
  input  wire  [7:0]  cfg_wr_data,
  // input items
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,   // [7:0] rx_byte, [9:8] byte_status, [15:10] zero
  input  wire  [0:0]  s_axis_tuser,   // [0] command
  // result items
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] reply_byte, [15:8] payload_byte,
                                      // [17:16] block_verdict, [18] finished,
                                      // [19] success, [23:20] zero
  output logic [1:0]  m_axis_tuser,   // [0] reply_valid, [1] payload_valid
  output logic        m_axis_tlast    // last_result
);

  // Input register: hold one item until the burst register can take its results.
  logic            in_valid;
  xcr_pkg::item_t  in_item;
  logic            fire;
  logic            can_load;
  logic            s_accept;

  xcr_pkg::result_t [xcr_pkg::MAX_RESULTS-1:0] core_res;
  logic [xcr_pkg::COUNT_W-1:0]                 core_count;
  xcr_pkg::result_t                            head;

  assign fire          = in_valid && can_load;
  assign s_axis_tready = !in_valid || fire;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  // payload of the input register needs no reset
  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_item.command     <= s_axis_tuser[0];
      in_item.rx_byte     <= s_axis_tdata[7:0];
      in_item.byte_status <= s_axis_tdata[9:8];
    end
  end

  // Engine: advance the transfer state and build the results of one item.
  xcr_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (fire),
    .item        (in_item),
    .res         (core_res),
    .res_count   (core_count)
  );

  // Burst register: drain the results one per cycle while the output is ready; items
  // with no results load an empty burst and pass straight through.
  xcr_burst u_burst (
    .clk        (clk),
    .rst        (rst),
    .load       (fire),
    .load_count (core_count),
    .load_res   (core_res),
    .can_load   (can_load),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_res    (head)
  );

  assign m_axis_tdata = {4'b0000, head.success, head.finished, head.block_verdict,
                         head.payload_byte, head.reply_byte};
  assign m_axis_tuser = {head.payload_valid, head.reply_valid};
  assign m_axis_tlast = head.last_result;

endmodule

`default_nettype wire

// File: design/xcr_checker.sv
// Port-level checks on the result stream of the XMODEM checksum receiver.
// Depends on xmodem_checksum_receiver_top_defines.svh; bound to the top level.
`default_nettype none
`include "xmodem_checksum_receiver_top_defines.svh"

module xcr_checker (
  input wire        clk,
  input wire        rst,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [23:0] m_axis_tdata,
  input wire [1:0]  m_axis_tuser,
  input wire        m_axis_tlast
);

  // a stalled result stays offered
  `XCR_ASSERT_NEXT(a_hold_valid, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

  // the closing result of a transfer is a reply and ends its burst
  `XCR_ASSERT_IMPLY(a_finish_last, clk, rst, m_axis_tvalid && m_axis_tdata[18], m_axis_tlast && m_axis_tuser[0], "finish not on last reply")

  // a result is a reply or a payload byte, never both
  `XCR_ASSERT_IMPLY(a_kind_excl, clk, rst, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]), "reply and payload together")

  // success only comes with finished
  `XCR_ASSERT_IMPLY(a_success_fin, clk, rst, m_axis_tvalid && m_axis_tdata[19], m_axis_tdata[18], "success without finished")

  // a verdict always rides on a reply byte
  `XCR_ASSERT_IMPLY(a_verdict_reply, clk, rst, m_axis_tvalid && (m_axis_tdata[17:16] != 2'd0), m_axis_tuser[0], "verdict without reply")

endmodule

bind xmodem_checksum_receiver_top xcr_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
